// ===== hw/rtl/alx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_pkg
// Shared types, token codes and character constants of the arrow lexer.
// ----------------------------------------------------------------------------
package alx_pkg;

	localparam logic [2:0] K_NAME_CHAR = 3'd0;
	localparam logic [2:0] K_LCPY      = 3'd1;
	localparam logic [2:0] K_LMOV      = 3'd2;
	localparam logic [2:0] K_RCPY      = 3'd3;
	localparam logic [2:0] K_RMOV      = 3'd4;
	localparam logic [2:0] K_SEMI      = 3'd5;
	localparam logic [2:0] K_NAME_END  = 3'd6;
	localparam logic [2:0] K_UNKNOWN   = 3'd7;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_LT   = 2'd1;
	localparam logic [1:0] PEND_DASH = 2'd2;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [1:0] MAX_EVENTS = 2'd3;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NAME,
		MODE_STRING,
		MODE_COMMENT
	} mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_source;
	} src_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] name_char;
		logic       name_start;
		logic       last_of_run;
	} tok_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] name_char;
		logic       name_start;
	} event_t;

	typedef struct packed {
		logic [1:0]       count;
		event_t [2:0]     ev;
	} grp_t;

endpackage

// ===== hw/rtl/alx_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_step
// Scanner update for one character: token events and next scan state.
// ----------------------------------------------------------------------------
module alx_step (
	input  alx_pkg::mode_t mode,
	input  logic [1:0]     pend,
	input  alx_pkg::src_t  src,
	output alx_pkg::mode_t mode_nxt,
	output logic [1:0]     pend_nxt,
	output alx_pkg::grp_t  grp
);

	function automatic alx_pkg::grp_t push(alx_pkg::grp_t g, logic [2:0] k,
		logic [7:0] c, logic s);
		alx_pkg::grp_t r;
		r = g;
		if (g.count != alx_pkg::MAX_EVENTS) begin
			r.ev[g.count].kind       = k;
			r.ev[g.count].name_char  = c;
			r.ev[g.count].name_start = s;
			r.count                  = g.count + 2'd1;
		end
		return r;
	endfunction

	logic [7:0] c;
	logic       ws;
	logic       term;
	logic       consumed;
	logic       do_idle;

	assign c    = src.ch;
	assign ws   = (c == alx_pkg::CH_SPACE) || (c >= alx_pkg::CH_TAB && c <= alx_pkg::CH_CR);
	assign term = ws || c == alx_pkg::CH_LT || c == alx_pkg::CH_GT ||
		c == alx_pkg::CH_SEMI || c == alx_pkg::CH_SLASH;

	always_comb begin
		grp      = '0;
		mode_nxt = mode;
		pend_nxt = pend;
		consumed = 1'b0;
		do_idle  = 1'b0;

		if (pend == alx_pkg::PEND_LT && c == alx_pkg::CH_DASH) begin
			grp      = push(grp, alx_pkg::K_LMOV, 8'h00, 1'b0);
			pend_nxt = alx_pkg::PEND_NONE;
			consumed = 1'b1;
		end else if (pend == alx_pkg::PEND_DASH && c == alx_pkg::CH_GT) begin
			grp      = push(grp, alx_pkg::K_RMOV, 8'h00, 1'b0);
			pend_nxt = alx_pkg::PEND_NONE;
			consumed = 1'b1;
		end else begin
			if (pend == alx_pkg::PEND_LT) begin
				grp = push(grp, alx_pkg::K_LCPY, 8'h00, 1'b0);
			end else if (pend == alx_pkg::PEND_DASH) begin
				grp = push(grp, alx_pkg::K_UNKNOWN, 8'h00, 1'b0);
			end
			pend_nxt = alx_pkg::PEND_NONE;
		end

		if (!consumed) begin
			unique case (mode)
				alx_pkg::MODE_COMMENT: begin
					if (c == alx_pkg::CH_SLASH) begin
						mode_nxt = alx_pkg::MODE_IDLE;
					end
				end
				alx_pkg::MODE_STRING: begin
					grp = push(grp, alx_pkg::K_NAME_CHAR, c, 1'b0);
					if (c == alx_pkg::CH_QUOTE) begin
						mode_nxt = alx_pkg::MODE_NAME;
					end
				end
				alx_pkg::MODE_NAME: begin
					if (term) begin
						grp      = push(grp, alx_pkg::K_NAME_END, 8'h00, 1'b0);
						mode_nxt = alx_pkg::MODE_IDLE;
						do_idle  = 1'b1;
					end else begin
						grp = push(grp, alx_pkg::K_NAME_CHAR, c, 1'b0);
						if (c == alx_pkg::CH_QUOTE) begin
							mode_nxt = alx_pkg::MODE_STRING;
						end
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase
		end

		if (do_idle && !ws) begin
			case (c)
				alx_pkg::CH_LT: pend_nxt = alx_pkg::PEND_LT;
				alx_pkg::CH_DASH: pend_nxt = alx_pkg::PEND_DASH;
				alx_pkg::CH_GT: grp = push(grp, alx_pkg::K_RCPY, 8'h00, 1'b0);
				alx_pkg::CH_SEMI: grp = push(grp, alx_pkg::K_SEMI, 8'h00, 1'b0);
				alx_pkg::CH_SLASH: mode_nxt = alx_pkg::MODE_COMMENT;
				default: begin
					grp      = push(grp, alx_pkg::K_NAME_CHAR, c, 1'b1);
					mode_nxt = (c == alx_pkg::CH_QUOTE) ? alx_pkg::MODE_STRING
						: alx_pkg::MODE_NAME;
				end
			endcase
		end

		if (src.end_of_source) begin
			if (pend_nxt == alx_pkg::PEND_LT) begin
				grp = push(grp, alx_pkg::K_LCPY, 8'h00, 1'b0);
			end else if (pend_nxt == alx_pkg::PEND_DASH) begin
				grp = push(grp, alx_pkg::K_UNKNOWN, 8'h00, 1'b0);
			end
			if (mode_nxt == alx_pkg::MODE_NAME || mode_nxt == alx_pkg::MODE_STRING) begin
				grp = push(grp, alx_pkg::K_NAME_END, 8'h00, 1'b0);
			end
			mode_nxt = alx_pkg::MODE_IDLE;
			pend_nxt = alx_pkg::PEND_NONE;
		end
	end

endmodule

// ===== hw/rtl/alx_evbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_evbuf
// Result register: holds the events of one character and hands them out
// one at a time as the consumer takes them, marking the last.
// ----------------------------------------------------------------------------
module alx_evbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  alx_pkg::grp_t grp,
	output logic          can_load,
	output logic          tok_valid,
	input  logic          tok_stall,
	output alx_pkg::tok_t tok
);

	logic [1:0]           cnt_q;
	alx_pkg::event_t [2:0] ev_q;
	logic                 take;

	assign take      = (cnt_q != 2'd0) && !tok_stall;
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);
	assign tok_valid = (cnt_q != 2'd0);

	always_comb begin
		tok.kind        = ev_q[0].kind;
		tok.name_char   = ev_q[0].name_char;
		tok.name_start  = ev_q[0].name_start;
		tok.last_of_run = (cnt_q == 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && can_load) begin
			cnt_q <= grp.count;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			ev_q <= grp.ev;
		end else if (take) begin
			ev_q[0] <= ev_q[1];
			ev_q[1] <= ev_q[2];
		end
	end

endmodule

// ===== hw/rtl/arrow_language_lexer_top.sv =====
`timescale 1ns / 1ps
// Path: a character is registered in src_s1, then its events in the result
// register. Throughput: one character per cycle while each yields at most one
// event and tok_stall is low; several events hold the register until all are taken.
// Reset: asynchronous, active low; clears scan mode, pending operator and
// all valid flags. The scanner also returns to reset state after end of source.
// ----------------------------------------------------------------------------
// arrow_language_lexer_top
// Streaming tokenizer: one source character per request, token events out.
// ----------------------------------------------------------------------------
module arrow_language_lexer_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_stall,
	input  alx_pkg::src_t src,
	output logic          tok_valid,
	input  logic          tok_stall,
	output alx_pkg::tok_t tok
);

	alx_pkg::src_t  src_s1;
	logic           valid_s1;
	alx_pkg::mode_t mode_q;
	logic [1:0]     pend_q;

	alx_pkg::mode_t mode_nxt;
	logic [1:0]     pend_nxt;
	alx_pkg::grp_t  grp;
	logic           can_load;
	logic           adv;
	logic           accept;

	alx_step u_step (
		.mode     (mode_q),
		.pend     (pend_q),
		.src      (src_s1),
		.mode_nxt (mode_nxt),
		.pend_nxt (pend_nxt),
		.grp      (grp)
	);

	alx_evbuf u_evbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && grp.count != 2'd0),
		.grp       (grp),
		.can_load  (can_load),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok)
	);

	assign adv       = valid_s1 && (grp.count == 2'd0 || can_load);
	assign src_stall = valid_s1 && !adv;
	assign accept    = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= alx_pkg::MODE_IDLE;
			pend_q   <= alx_pkg::PEND_NONE;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				mode_q <= mode_nxt;
				pend_q <= pend_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1 <= src;
		end
	end

endmodule

// ===== hw/rtl/alx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alx_checker
// Port-level checks of the lexer, bound to the top level.
// ----------------------------------------------------------------------------
module alx_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          src_valid,
	input logic          src_stall,
	input logic          tok_valid,
	input logic          tok_stall,
	input alx_pkg::tok_t tok
);

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok))
		else $error("token changed while stalled");

	a_non_name_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok.kind != alx_pkg::K_NAME_CHAR |->
		tok.name_char == 8'h00 && !tok.name_start)
		else $error("non-name token carries character data");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_stall && !tok.last_of_run |=> tok_valid)
		else $error("run ended without last mark");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> tok_valid)
		else $error("input stalled with empty result register");

	a_tok_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tok_valid) |-> $past(src_valid && !src_stall, 2))
		else $error("token without a request two cycles earlier");

endmodule

bind arrow_language_lexer_top alx_checker u_alx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.tok_valid (tok_valid),
	.tok_stall (tok_stall),
	.tok       (tok)
);
